@@ sv/lph_pkg.sv @@
// Shared types and constants for the linear-probe hash table.
`default_nettype none
package lph_pkg;
    localparam int Capacity  = 1024;
    localparam int IdxW      = $clog2(Capacity);
    localparam int CntW      = IdxW + 1;
    localparam int KeyW      = 32;
    localparam int ValW      = 32;
    localparam int HashW     = 32;
    localparam int CfgW      = 11;
    localparam int ReduceW   = HashW + CntW;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_USED  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]      mode;
        logic [KeyW-1:0] key;
        logic [HashW-1:0] key_hash;
        logic [ValW-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [ValW-1:0] value_out;
    } t_rsp;

    typedef struct packed {
        logic [1:0]      mode;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
        logic [IdxW-1:0] start;
        logic [CntW-1:0] slots;
    } t_job;
endpackage
`default_nettype wire

@@ sv/lph_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module lph_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_addr,
    input  wire  [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ sv/lph_front.sv @@
// Front end: accept requests, reduce the hash modulo the slot count, queue jobs.
`default_nettype none
module lph_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  lph_pkg::t_req       i_req,
    input  wire  [lph_pkg::CfgW-1:0] i_slots_cfg,
    output logic                o_busy,
    output logic                o_job_valid,
    output lph_pkg::t_job       o_job,
    input  wire                 i_job_take
);
    import lph_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_QUEUE} t_state;

    t_state              r_state, n_state;
    t_req                r_req;
    logic [ReduceW-1:0]  r_rem, n_rem;
    logic [5:0]          r_bit, n_bit;
    logic [CntW-1:0]     w_slots;
    logic [ReduceW-1:0]  w_shifted;
    t_job                r_q [2];
    logic [1:0]          r_cnt;
    logic                r_wp, r_rp;
    logic                w_push;

    always_comb begin
        if (i_slots_cfg == '0) begin
            w_slots = CntW'(1);
        end else if (i_slots_cfg > CfgW'(Capacity)) begin
            w_slots = CntW'(Capacity);
        end else begin
            w_slots = CntW'(i_slots_cfg);
        end
    end

    // restoring remainder: one hash bit per cycle
    assign w_shifted = ReduceW'(w_slots) << r_bit;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_bit   = r_bit;
        w_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rem   = ReduceW'(i_req.key_hash);
                    n_bit   = 6'(HashW - 1);
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_rem >= w_shifted) begin
                    n_rem = r_rem - w_shifted;
                end
                if (r_bit == '0) begin
                    n_state = S_QUEUE;
                end else begin
                    n_bit = r_bit - 6'd1;
                end
            end
            S_QUEUE: begin
                if (r_cnt != 2'd2) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_job_take};
        end
        r_rem <= n_rem;
        r_bit <= n_bit;
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req;
        end
        if (w_push) begin
            r_q[r_wp] <= '{mode: r_req.mode, key: r_req.key, value: r_req.value,
                           start: IdxW'(r_rem), slots: w_slots};
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    a_take_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_take |-> r_cnt != '0) else $error("take from empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overflow");
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> r_rem < ReduceW'(w_slots)) else $error("bad remainder");
endmodule
`default_nettype wire

@@ sv/lph_back.sv @@
// Back end: clear the tag memory after reset, then probe the slot memories and write results.
`default_nettype none
module lph_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  lph_pkg::t_job       i_job,
    output logic                o_job_take,
    output logic                o_done,
    output lph_pkg::t_rsp       o_rsp
);
    import lph_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DONE} t_state;

    t_state           r_state;
    t_job             r_job;
    logic [IdxW-1:0]  r_idx;
    logic [CntW-1:0]  r_cnt;
    logic [1:0]       w_tag;
    logic [KeyW-1:0]  w_key;
    logic [ValW-1:0]  w_val;
    logic             w_we_tag, w_we_kv;
    logic [1:0]       w_tag_wd;
    logic [IdxW-1:0]  w_nidx;
    logic [1:0]       r_status;
    logic [ValW-1:0]  r_vout;

    lph_ram #(.Width(2), .Depth(Capacity)) u_tag (
        .i_clk(i_clk), .i_we(w_we_tag), .i_addr(r_idx), .i_wdata(w_tag_wd), .o_rdata(w_tag));
    lph_ram #(.Width(KeyW), .Depth(Capacity)) u_key (
        .i_clk(i_clk), .i_we(w_we_kv && r_job.mode == MODE_INSERT && w_tag != TAG_USED),
        .i_addr(r_idx), .i_wdata(r_job.key), .o_rdata(w_key));
    lph_ram #(.Width(ValW), .Depth(Capacity)) u_val (
        .i_clk(i_clk), .i_we(w_we_kv), .i_addr(r_idx), .i_wdata(r_job.value), .o_rdata(w_val));

    assign w_nidx = (CntW'(r_idx) + CntW'(1) == r_job.slots) ? '0 : r_idx + IdxW'(1);

    always_comb begin
        w_we_tag = 1'b0;
        w_we_kv  = 1'b0;
        w_tag_wd = TAG_EMPTY;
        if (r_state == S_CLEAR) begin
            w_we_tag = 1'b1;
        end else if (r_state == S_EVAL) begin
            if (r_job.mode == MODE_INSERT) begin
                if (w_tag != TAG_USED) begin
                    w_we_tag = 1'b1;
                    w_tag_wd = TAG_USED;
                    w_we_kv  = 1'b1;
                end else if (w_key == r_job.key) begin
                    w_we_kv = 1'b1;
                end
            end else if (r_job.mode == MODE_DELETE && w_tag == TAG_USED
                         && w_key == r_job.key) begin
                w_we_tag = 1'b1;
                w_tag_wd = TAG_TOMB;
            end
        end
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + IdxW'(1);
                    if (r_idx == IdxW'(Capacity - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_idx   <= i_job.start;
                        r_cnt   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_state <= S_DONE;
                    r_vout  <= '0;
                    if (r_job.mode == MODE_INSERT) begin
                        if (w_tag != TAG_USED) begin
                            r_status <= ST_NEW;
                        end else if (w_key == r_job.key) begin
                            r_status <= ST_FOUND;
                        end else if (r_cnt + CntW'(1) == r_job.slots) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_idx <= w_nidx; r_cnt <= r_cnt + CntW'(1); r_state <= S_READ;
                        end
                    end else if (r_job.mode == MODE_SEARCH || r_job.mode == MODE_DELETE) begin
                        if (w_tag == TAG_EMPTY || r_cnt + CntW'(1) == r_job.slots
                            && !(w_tag == TAG_USED && w_key == r_job.key)) begin
                            r_status <= ST_MISS;
                        end else if (w_tag == TAG_USED && w_key == r_job.key) begin
                            r_status <= ST_FOUND;
                            r_vout   <= w_val;
                        end else begin
                            r_idx <= w_nidx; r_cnt <= r_cnt + CntW'(1); r_state <= S_READ;
                        end
                    end else begin
                        r_status <= ST_MISS;
                    end
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = '{status: r_status, value_out: r_vout};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done out of sequence");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> r_cnt < r_job.slots) else $error("probe overrun");
    a_ins_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_job.mode == MODE_INSERT |-> o_rsp.value_out == '0)
        else $error("insert returned value");
endmodule
`default_nettype wire

@@ sv/linear_probe_hash_table_core.sv @@
// Top level of the linear-probe hash table.
// One request is taken when start is high and busy is low; its single
// result appears with o_done for one cycle and cannot be held off. The front
// end reduces the hash modulo the slot count one bit per cycle; busy stays high
// until the job is queued, so the front takes no new request before the last
// one is queued. The back end takes a job, then reads and evaluates each probed
// slot in turn (S_READ, then S_EVAL) and finishes in S_DONE. A two-entry queue
// lets the front reduce the next hash while the back probes; when it is full,
// busy stays high until the back takes a job. After reset the back end clears
// the tag memory, during which requests wait in the queue.
`default_nettype none
module linear_probe_hash_table_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  lph_pkg::t_req            i_req,
    input  wire                      i_cfg_we,
    input  wire  [lph_pkg::CfgW-1:0] i_cfg_wdata,
    output logic                     o_done,
    output lph_pkg::t_rsp            o_rsp
);
    import lph_pkg::*;

    logic [CfgW-1:0] r_slots;
    logic            w_job_valid, w_job_take;
    t_job            w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= CfgW'(Capacity);
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_wdata;
        end
    end

    lph_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_req),
        .i_slots_cfg(r_slots), .o_busy(busy), .o_job_valid(w_job_valid),
        .o_job(w_job), .i_job_take(w_job_take));

    lph_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_job_valid), .i_job(w_job),
        .o_job_take(w_job_take), .o_done(o_done), .o_rsp(o_rsp));
endmodule
`default_nettype wire
